### rtl/core/phred_weighted_base_counter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the phred weighted base counter RTL.
// ----------------------------------------------------------------------------
`ifndef PHRED_WEIGHTED_BASE_COUNTER_UNIT_ASSERT_SVH
`define PHRED_WEIGHTED_BASE_COUNTER_UNIT_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define PBC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define PBC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### rtl/core/pbc_pkg.sv
// ----------------------------------------------------------------------------
// pbc_pkg
// Types, constants and the mapping-weight ROM of the phred weighted base
// counter.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int SUM_INT_BITS     = 16;

    localparam int POS_W   = 32;
    localparam int QUAL_W  = 8;
    localparam int INDEL_W = 2;
    localparam int CODE_W  = 4;
    localparam int COUNT_W = 16;

    localparam int W_W      = WEIGHT_FRAC_BITS;
    localparam int SUM_W    = SUM_INT_BITS + WEIGHT_FRAC_BITS;
    localparam int NUM_BINS = 6;
    localparam int ROM_DEPTH = 1 << QUAL_W;

    localparam int BIN_A   = 0;
    localparam int BIN_C   = 1;
    localparam int BIN_G   = 2;
    localparam int BIN_T   = 3;
    localparam int BIN_INS = 4;
    localparam int BIN_DEL = 5;

    localparam logic [CODE_W-1:0] CODE_A = 4'h1;
    localparam logic [CODE_W-1:0] CODE_C = 4'h2;
    localparam logic [CODE_W-1:0] CODE_G = 4'h4;
    localparam logic [CODE_W-1:0] CODE_T = 4'h8;

    localparam logic [INDEL_W-1:0] INDEL_INSERT = 2'd1;
    localparam logic [INDEL_W-1:0] INDEL_DELETE = 2'd2;

    localparam logic [W_W-1:0]     HALF_LSB  = W_W'(1) << (W_W - 1);
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Step ratio of the decaying exponential, about exp(-0.1) in Q0.32.
    localparam logic [31:0] ROM_RATIO = 32'd3886247119;

    typedef logic [W_W-1:0] weight_rom_t [ROM_DEPTH];
    typedef logic [NUM_BINS-1:0][SUM_W-1:0] sums_t;
    typedef logic [NUM_BINS-1:0][COUNT_W-1:0] counts_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               carries_read;
        logic [QUAL_W-1:0]  map_quality;
        logic [INDEL_W-1:0] indel_kind;
        logic               deleted_here;
        logic [CODE_W-1:0]  base_code;
        logic [QUAL_W-1:0]  base_quality;
        logic               last_of_column;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic                last;
        logic [NUM_BINS-1:0] hit;
        logic [W_W-1:0]      add;
    } weighed_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        sums_t            sums;
    } column_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        counts_t          counts;
    } result_t;

    // Builds 1 - exp(-0.1*q) for every quality q, rounded to the weight format.
    function automatic weight_rom_t build_weight_rom();
        weight_rom_t rom;
        logic [65:0] e;
        logic [32:0] one_minus;
        logic [32:0] w;
        e = 66'd1 << 32;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            one_minus = (33'd1 << 32) - e[32:0];
            w = (one_minus + (33'd1 << (31 - W_W))) >> (32 - W_W);
            if (w > 33'({W_W{1'b1}}))
            begin
                w = 33'({W_W{1'b1}});
            end
            rom[i] = w[W_W-1:0];
            e = (e * 66'(ROM_RATIO) + (66'd1 << 31)) >> 32;
        end
        return rom;
    endfunction

    localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

### rtl/core/pbc_weigh.sv
// ----------------------------------------------------------------------------
// pbc_weigh
// Input register, weight lookup and base-quality product; picks the bin that
// the read feeds and registers the value to add.
// ----------------------------------------------------------------------------
module pbc_weigh
    import pbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  item_t    in_item,
    input  logic     take,
    output logic     s2_valid,
    output weighed_t s2_item
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    item_t    s1_item_reg;
    logic     s2_valid_reg;
    logic     s2_valid_next;
    weighed_t s2_item_reg;
    weighed_t s2_item_next;

    logic s1_free;
    logic s1_go;
    logic s2_free;

    logic [W_W-1:0]    w_map;
    logic [W_W-1:0]    w_base;
    logic [2*W_W-1:0]  product;
    logic [NUM_BINS-1:0] base_hit;

    assign s2_free  = !s2_valid_reg || take;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;
    assign in_stall = !s1_free;

    assign s1_valid_next = s1_free ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;

    assign w_map   = WEIGHT_ROM[s1_item_reg.map_quality];
    assign w_base  = WEIGHT_ROM[s1_item_reg.base_quality];
    assign product = w_map * w_base + (2*W_W)'(HALF_LSB);

    always_comb
    begin
        base_hit = '0;
        unique case (s1_item_reg.base_code)
            CODE_A:  base_hit[BIN_A] = 1'b1;
            CODE_C:  base_hit[BIN_C] = 1'b1;
            CODE_G:  base_hit[BIN_G] = 1'b1;
            CODE_T:  base_hit[BIN_T] = 1'b1;
            default: base_hit = '0;
        endcase
    end

    always_comb
    begin
        s2_item_next.position = s1_item_reg.position;
        s2_item_next.last     = s1_item_reg.last_of_column;
        s2_item_next.hit      = '0;
        s2_item_next.add      = product[2*W_W-1:W_W];
        priority if (!s1_item_reg.carries_read || s1_item_reg.map_quality == '0)
        begin
            s2_item_next.hit = '0;
        end
        else if (s1_item_reg.indel_kind == INDEL_INSERT)
        begin
            s2_item_next.hit[BIN_INS] = 1'b1;
            s2_item_next.add          = w_map;
        end
        else if (s1_item_reg.indel_kind == INDEL_DELETE)
        begin
            s2_item_next.hit[BIN_DEL] = 1'b1;
            s2_item_next.add          = w_map;
        end
        else if (!s1_item_reg.deleted_here)
        begin
            s2_item_next.hit = base_hit;
        end
        else
        begin
            s2_item_next.hit = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_go)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_item_reg;

endmodule

### rtl/core/pbc_accum.sv
// ----------------------------------------------------------------------------
// pbc_accum
// Six saturating bin sums; the column's last item copies the final sums to a
// hand-off register and clears them.
// ----------------------------------------------------------------------------
`include "phred_weighted_base_counter_unit_assert.svh"

module pbc_accum
    import pbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s2_valid,
    input  weighed_t s2_item,
    output logic     take,
    input  logic     out_free,
    output logic     snap_valid,
    output column_t  snap
);

    sums_t   sum_reg;
    sums_t   sum_next;
    sums_t   added;
    logic    snap_valid_reg;
    logic    snap_valid_next;
    column_t snap_reg;
    logic    snap_free;

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s, logic [W_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(v);
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    assign snap_free = !snap_valid_reg || out_free;
    assign take      = s2_valid && (!s2_item.last || snap_free);

    always_comb
    begin
        for (int i = 0; i < NUM_BINS; i++)
        begin
            added[i] = s2_item.hit[i] ? sat_add(sum_reg[i], s2_item.add) : sum_reg[i];
        end
        if (take)
        begin
            sum_next = s2_item.last ? '0 : added;
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    always_comb
    begin
        if (take && s2_item.last)
        begin
            snap_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s2_item.last)
        begin
            snap_reg.position <= s2_item.position;
            snap_reg.sums     <= added;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // A closed column must wait for the result register without being overwritten.
    `PBC_ASSERT_NEXT(a_snap_hold, clk, rst_n, snap_valid_reg && !out_free, snap_valid_reg && $stable(snap_reg), "closed column changed while waiting")
    `PBC_ASSERT_NEXT(a_clear_after_close, clk, rst_n, take && s2_item.last, sum_reg == '0, "bin sums not cleared after column close")
    `PBC_ASSERT(a_single_bin, clk, rst_n, !s2_valid || $onehot0(s2_item.hit), "read feeds more than one bin")

endmodule

### rtl/core/pbc_scale.sv
// ----------------------------------------------------------------------------
// pbc_scale
// Scales each closed bin sum by ten, rounds and saturates it to the count
// width, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module pbc_scale
    import pbc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    snap_valid,
    input  column_t snap,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t result
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t result_next;

    // Times ten is eight times plus two times, then rounded half up.
    function automatic logic [COUNT_W-1:0] scale_out(logic [SUM_W-1:0] s);
        logic [SUM_W+3:0] m;
        logic [SUM_W+3:0] r;
        m = (SUM_W+4)'({s, 3'b000}) + (SUM_W+4)'({s, 1'b0}) + (SUM_W+4)'(HALF_LSB);
        r = m >> W_W;
        return (r > (SUM_W+4)'(COUNT_MAX)) ? COUNT_MAX : r[COUNT_W-1:0];
    endfunction

    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid_next = out_free ? snap_valid : out_valid_reg;

    always_comb
    begin
        result_next.position = snap.position;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            result_next.counts[i] = scale_out(snap.sums[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_valid && out_free)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

### rtl/core/phred_weighted_base_counter_unit.sv
// ----------------------------------------------------------------------------
// phred_weighted_base_counter_unit
// Accumulates phred-weighted A, C, G, T, insertion and deletion evidence for
// one genome column, one read per transfer, and emits the scaled counts.
//
// Channel   Handshake            Payload
// input     in_valid / in_stall  position .. last_of_column, one read
// output    out_valid / out_stall column_position, count_a .. count_delete
//
// One read is taken every cycle while in_stall is low. A column's result is valid
// once its last item has landed in the input register and then passed the
// weight ROM and multiplier, the bin sums with their hand-off register, and
// the scaling into the result register.
// Reset clears the bin sums and all valid bits at once.
// A stalled result holds in its register while reads keep flowing into the
// sums; input stalls only when a column closes while two earlier results wait.
// ----------------------------------------------------------------------------
module phred_weighted_base_counter_unit
    import pbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [POS_W-1:0]   position,
    input  logic               carries_read,
    input  logic [QUAL_W-1:0]  map_quality,
    input  logic [INDEL_W-1:0] indel_kind,
    input  logic               deleted_here,
    input  logic [CODE_W-1:0]  base_code,
    input  logic [QUAL_W-1:0]  base_quality,
    input  logic               last_of_column,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [POS_W-1:0]   column_position,
    output logic [COUNT_W-1:0] count_a,
    output logic [COUNT_W-1:0] count_c,
    output logic [COUNT_W-1:0] count_g,
    output logic [COUNT_W-1:0] count_t,
    output logic [COUNT_W-1:0] count_insert,
    output logic [COUNT_W-1:0] count_delete
);

    item_t    in_item;
    logic     s2_valid;
    weighed_t s2_item;
    logic     take;
    logic     out_free;
    logic     snap_valid;
    column_t  snap;
    result_t  result;

    assign in_item.position       = position;
    assign in_item.carries_read   = carries_read;
    assign in_item.map_quality    = map_quality;
    assign in_item.indel_kind     = indel_kind;
    assign in_item.deleted_here   = deleted_here;
    assign in_item.base_code      = base_code;
    assign in_item.base_quality   = base_quality;
    assign in_item.last_of_column = last_of_column;

    pbc_weigh u_weigh (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .take     (take),
        .s2_valid (s2_valid),
        .s2_item  (s2_item)
    );

    pbc_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2_valid   (s2_valid),
        .s2_item    (s2_item),
        .take       (take),
        .out_free   (out_free),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    pbc_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign column_position = result.position;
    assign count_a         = result.counts[BIN_A];
    assign count_c         = result.counts[BIN_C];
    assign count_g         = result.counts[BIN_G];
    assign count_t         = result.counts[BIN_T];
    assign count_insert    = result.counts[BIN_INS];
    assign count_delete    = result.counts[BIN_DEL];

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: regression bench for phred_weighted_base_counter_unit
// The bench drives read items through the input channel and checks every
// closed column against a cycle-free predictor of the weighted bin sums.
// It runs a directed table first, then random columns. Both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pbc_pkg::*;

    localparam logic [INDEL_W-1:0] INDEL_NONE  = 2'd0;
    localparam logic [INDEL_W-1:0] INDEL_SPARE = 2'd3;
    localparam logic [CODE_W-1:0]  CODE_NONE   = 4'h0;
    localparam logic [CODE_W-1:0]  CODE_MIXED  = 4'h3;
    localparam logic [CODE_W-1:0]  CODE_ALL    = 4'hF;
    localparam logic [W_W-1:0]     WEIGHT_TOP  = '1;
    localparam int OUT_SCALE    = 10;
    localparam int DIRECTED_N   = 19;
    localparam int RANDOM_READS = 1880;

    typedef struct packed {
        item_t   it;
        logic    typed;
        counts_t counts;
        logic    calm;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [POS_W-1:0]   position;
    logic               carries_read;
    logic [QUAL_W-1:0]  map_quality;
    logic [INDEL_W-1:0] indel_kind;
    logic               deleted_here;
    logic [CODE_W-1:0]  base_code;
    logic [QUAL_W-1:0]  base_quality;
    logic               last_of_column;
    logic               out_valid;
    logic               out_stall;
    logic [POS_W-1:0]   column_position;
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_c;
    logic [COUNT_W-1:0] count_g;
    logic [COUNT_W-1:0] count_t;
    logic [COUNT_W-1:0] count_insert;
    logic [COUNT_W-1:0] count_delete;

    logic [W_W-1:0]   qual_weight [ROM_DEPTH];
    logic [SUM_W-1:0] bin_sum [NUM_BINS] = '{default: '0};
    row_t             feed_q [$];
    result_t          column_q [$];
    int               taken = 0;
    int               mismatches = 0;
    string            bin_label [NUM_BINS] = '{"A", "C", "G", "T", "insert", "delete"};
    logic [CODE_W-1:0] base_codes [4] = '{CODE_A, CODE_C, CODE_G, CODE_T};

    // One full-weight read (quality 255) scores ten after scaling, so these
    // expectations can be read off at a glance.
    row_t directed [DIRECTED_N] = '{
        '{'{32'h0000_0000, 1'b0, 8'd0, INDEL_NONE, 1'b0, CODE_NONE, 8'd0, 1'b1},
          1'b1, '{default: 16'd0}, 1'b0},
        '{'{32'hFFFF_FFFF, 1'b1, 8'd255, INDEL_INSERT, 1'b0, CODE_NONE, 8'd0, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'hFFFF_FFFF, 1'b1, 8'd255, INDEL_DELETE, 1'b1, CODE_NONE, 8'd0, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'hFFFF_FFFF, 1'b1, 8'd255, INDEL_NONE, 1'b0, CODE_A, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'hFFFF_FFFF, 1'b1, 8'd255, INDEL_NONE, 1'b0, CODE_C, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'hFFFF_FFFF, 1'b1, 8'd255, INDEL_NONE, 1'b0, CODE_G, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'hFFFF_FFFF, 1'b1, 8'd255, INDEL_NONE, 1'b0, CODE_T, 8'd255, 1'b1},
          1'b1, '{default: 16'd10}, 1'b0},
        '{'{32'h0000_0001, 1'b1, 8'd0, INDEL_INSERT, 1'b0, CODE_NONE, 8'd0, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0001, 1'b1, 8'd0, INDEL_NONE, 1'b0, CODE_A, 8'd255, 1'b1},
          1'b1, '{default: 16'd0}, 1'b0},
        '{'{32'h0000_0002, 1'b1, 8'd255, INDEL_INSERT, 1'b0, CODE_A, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0002, 1'b1, 8'd255, INDEL_NONE, 1'b1, CODE_C, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0002, 1'b1, 8'd255, INDEL_NONE, 1'b0, CODE_MIXED, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0002, 1'b1, 8'd255, INDEL_NONE, 1'b0, CODE_ALL, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0002, 1'b1, 8'd255, INDEL_NONE, 1'b0, CODE_NONE, 8'd255, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0002, 1'b0, 8'd255, INDEL_INSERT, 1'b0, CODE_NONE, 8'd0, 1'b1},
          1'b1, '{BIN_INS: 16'd10, default: 16'd0}, 1'b0},
        '{'{32'h0000_0003, 1'b1, 8'd1, INDEL_SPARE, 1'b0, CODE_G, 8'd40, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0003, 1'b1, 8'd1, INDEL_DELETE, 1'b0, CODE_NONE, 8'd0, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h0000_0003, 1'b1, 8'd30, INDEL_NONE, 1'b0, CODE_A, 8'd0, 1'b0},
          1'b0, '0, 1'b0},
        '{'{32'h8000_0000, 1'b1, 8'd128, INDEL_DELETE, 1'b1, CODE_T, 8'd200, 1'b1},
          1'b0, '0, 1'b0}
    };

    phred_weighted_base_counter_unit uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #25ms;
        $display("phred_weighted_base_counter_unit regression: fail");
        $finish;
    end

    // Mostly back to back, now and then a short gap, rarely a long one.
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    // Adds one read to the bin sums; on the column's last item it also
    // returns the scaled counts and clears the sums.
    task automatic absorb_read(input item_t it, output logic closes, output result_t col);
        logic [W_W-1:0]   w_map;
        logic [2*W_W:0]   prod;
        logic [SUM_W:0]   total;
        logic [SUM_W+4:0] scaled;
        logic [SUM_W-1:0] gain;
        int               bin;
        bin = -1;
        gain = '0;
        w_map = qual_weight[it.map_quality];
        if (it.carries_read && it.map_quality != '0)
        begin
            if (it.indel_kind == INDEL_INSERT)
            begin
                bin = BIN_INS;
                gain = SUM_W'(w_map);
            end
            else if (it.indel_kind == INDEL_DELETE)
            begin
                bin = BIN_DEL;
                gain = SUM_W'(w_map);
            end
            else if (!it.deleted_here)
            begin
                case (it.base_code)
                    CODE_A: bin = BIN_A;
                    CODE_C: bin = BIN_C;
                    CODE_G: bin = BIN_G;
                    CODE_T: bin = BIN_T;
                    default: bin = -1;
                endcase
                prod = w_map * qual_weight[it.base_quality];
                prod = prod + HALF_LSB;
                gain = SUM_W'(prod >> W_W);
            end
        end
        if (bin >= 0)
        begin
            total = bin_sum[bin] + gain;
            bin_sum[bin] = (total > SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
        end
        closes = it.last_of_column;
        col.position = it.position;
        col.counts = '0;
        if (closes)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                scaled = bin_sum[b] * OUT_SCALE + HALF_LSB;
                scaled = scaled >> W_W;
                col.counts[b] = (scaled > COUNT_MAX) ? COUNT_MAX : scaled[COUNT_W-1:0];
                bin_sum[b] = '0;
            end
        end
    endtask

    task automatic check_column(input result_t seen);
        result_t want;
        if (column_q.size() == 0)
        begin
            report_mismatch($sformatf("column %0h arrived with nothing expected",
                                      seen.position));
            return;
        end
        want = column_q.pop_front();
        if (seen.position != want.position)
            report_mismatch($sformatf("column position %0h, expected %0h",
                                      seen.position, want.position));
        for (int b = 0; b < NUM_BINS; b++)
        begin
            if (seen.counts[b] != want.counts[b])
                report_mismatch($sformatf("column %0h: %s count %0d, expected %0d",
                                          want.position, bin_label[b],
                                          seen.counts[b], want.counts[b]));
        end
    endtask

    always @(posedge clk)
    begin : watch
        row_t    row;
        result_t col;
        result_t seen;
        logic    closes;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                row = feed_q[taken];
                taken++;
                absorb_read(row.it, closes, col);
                if (closes)
                begin
                    // Table rows with spelled-out counts take precedence.
                    if (row.typed)
                        col.counts = row.counts;
                    column_q.push_back(col);
                end
            end
            if (out_valid && !out_stall)
            begin
                seen.position = column_position;
                seen.counts[BIN_A] = count_a;
                seen.counts[BIN_C] = count_c;
                seen.counts[BIN_G] = count_g;
                seen.counts[BIN_T] = count_t;
                seen.counts[BIN_INS] = count_insert;
                seen.counts[BIN_DEL] = count_delete;
                check_column(seen);
            end
        end
    end

    initial
    begin : drain
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            int n;
            n = idle_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(20, 80)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

    initial
    begin : feed
        logic [65:0]      decay;
        logic [32:0]      rise;
        logic [POS_W-1:0] col_pos;
        row_t             r;
        int               gap;
        int               roll;
        int               span;
        int               random_reads;
        logic             calm;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        {position, carries_read, map_quality, indel_kind, deleted_here,
         base_code, base_quality, last_of_column} <= '0;

        // Quality weight 1 - exp(-0.1*q): the decaying term is stepped in
        // Q0.32 and the complement is rounded to the weight format.
        decay = 66'd1 << 32;
        for (int q = 0; q < ROM_DEPTH; q++)
        begin
            rise = (33'd1 << 32) - decay[32:0];
            rise = (rise + (33'd1 << (31 - W_W))) >> (32 - W_W);
            qual_weight[q] = (rise > WEIGHT_TOP) ? WEIGHT_TOP : rise[W_W-1:0];
            decay = (decay * ROM_RATIO + (66'd1 << 31)) >> 32;
        end

        foreach (directed[k])
            feed_q.push_back(directed[k]);

        random_reads = 0;
        while (random_reads < RANDOM_READS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 75)
                span = $urandom_range(1, 8);
            else if (roll < 95)
                span = $urandom_range(9, 40);
            else
                span = $urandom_range(41, 160);
            calm = ($urandom_range(0, 3) == 0);
            col_pos = $urandom();
            for (int k = 0; k < span; k++)
            begin
                r = '0;
                r.calm = calm;
                r.it.position = ($urandom_range(0, 9) == 0) ? $urandom() : col_pos;
                r.it.carries_read = ($urandom_range(0, 19) != 0);
                if ($urandom_range(0, 9) == 0)
                    r.it.map_quality = 8'd0;
                else if ($urandom_range(0, 1) == 0)
                    r.it.map_quality = QUAL_W'($urandom_range(1, 60));
                else
                    r.it.map_quality = QUAL_W'($urandom_range(1, 255));
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    r.it.indel_kind = INDEL_NONE;
                else if (roll == 7)
                    r.it.indel_kind = INDEL_INSERT;
                else if (roll == 8)
                    r.it.indel_kind = INDEL_DELETE;
                else
                    r.it.indel_kind = INDEL_SPARE;
                r.it.deleted_here = ($urandom_range(0, 9) == 0);
                if ($urandom_range(0, 6) == 0)
                    r.it.base_code = CODE_W'($urandom_range(0, 15));
                else
                    r.it.base_code = base_codes[$urandom_range(0, 3)];
                if ($urandom_range(0, 1) == 0)
                    r.it.base_quality = QUAL_W'($urandom_range(0, 60));
                else
                    r.it.base_quality = QUAL_W'($urandom_range(0, 255));
                r.it.last_of_column = (k == span - 1);
                feed_q.push_back(r);
            end
            random_reads += span;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < feed_q.size(); k++)
        begin
            gap = feed_q[k].calm ? 0 : idle_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            {position, carries_read, map_quality, indel_kind, deleted_here,
             base_code, base_quality, last_of_column} <= feed_q[k].it;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (column_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("phred_weighted_base_counter_unit regression: pass");
        else
            $display("phred_weighted_base_counter_unit regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pbc_pkg.sv
rtl/core/pbc_weigh.sv
rtl/core/pbc_accum.sv
rtl/core/pbc_scale.sv
rtl/core/phred_weighted_base_counter_unit.sv
tb/sv/tb_top.sv
